@@ hdl/dtlb_pkg.sv @@
// Shared types, register codes and reset constants for the LED blinker
`default_nettype none
package dtlb_pkg;

    localparam int CHANNELS_DEFAULT = 4;
    localparam int HP_REGS          = 4;
    localparam int FIELD_W          = 4;
    localparam int HP_W             = 16;
    localparam int DEB_W            = 10;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [HP_W-1:0] HP_RESET [HP_REGS] =
        '{16'd250, 16'd500, 16'd750, 16'd1000};
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 10'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HP0      = 3'd0,
        CFG_HP1      = 3'd1,
        CFG_HP2      = 3'd2,
        CFG_HP3      = 3'd3,
        CFG_DEBOUNCE = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic led;
        logic enabled;
    } lane_status_t;

    typedef struct packed {
        logic skid_full;
        logic out_full;
    } merge_status_t;

endpackage
`default_nettype wire

@@ hdl/dtlb_lane.sv @@
// One LED channel: blink counter, debounce counter and enable flag
`default_nettype none
module dtlb_lane
    import dtlb_pkg::*;
#(
    parameter logic [HP_W-1:0] HP_INIT = HP_RESET[0]
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tick,
    input  wire logic             edge_seen,
    input  wire logic [HP_W-1:0]  half_period,
    input  wire logic [DEB_W-1:0] debounce_ticks,
    output lane_status_t          status_next
);

    logic             enabled_reg, enabled_next;
    logic             led_reg, led_next;
    logic [HP_W-1:0]  blink_count_reg, blink_count_next;
    logic [DEB_W-1:0] debounce_count_reg, debounce_count_next;
    logic [HP_W-1:0]  period;
    logic [DEB_W-1:0] debounce_load;

    assign period        = (half_period == '0) ? HP_W'(1) : half_period;
    assign debounce_load = (debounce_ticks == '0) ? DEB_W'(1) : debounce_ticks;

    always_comb
    begin
        enabled_next        = enabled_reg;
        led_next            = led_reg;
        blink_count_next    = blink_count_reg;
        debounce_count_next = debounce_count_reg;

        if (enabled_reg)
        begin
            if (blink_count_reg <= HP_W'(1))
            begin
                led_next         = ~led_reg;
                blink_count_next = period;
            end
            else
            begin
                blink_count_next = blink_count_reg - HP_W'(1);
            end
        end

        if (edge_seen)
        begin
            debounce_count_next = debounce_load;
        end
        else if (debounce_count_reg != '0)
        begin
            debounce_count_next = debounce_count_reg - DEB_W'(1);
            if (debounce_count_reg == DEB_W'(1))
            begin
                enabled_next = ~enabled_reg;
                if (!enabled_reg)
                begin
                    led_next         = 1'b1;
                    blink_count_next = period;
                end
                else
                begin
                    led_next = 1'b0;
                end
            end
        end

        status_next.led     = led_next;
        status_next.enabled = enabled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg        <= 1'b1;
            led_reg            <= 1'b1;
            blink_count_reg    <= HP_INIT;
            debounce_count_reg <= '0;
        end
        else if (tick)
        begin
            enabled_reg        <= enabled_next;
            led_reg            <= led_next;
            blink_count_reg    <= blink_count_next;
            debounce_count_reg <= debounce_count_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/dtlb_merge.sv @@
// Merge of lane results into the output word, with output register and skid stage
`default_nettype none
module dtlb_merge
    import dtlb_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lane_status_t  lanes [CHANNELS],
    output logic               accept_ready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output merge_status_t      status
);

    localparam int SHOWN = (CHANNELS < FIELD_W) ? CHANNELS : FIELD_W;

    logic [FIELD_W-1:0] levels, enables;
    logic [7:0]         word;
    logic [7:0]         out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               pop;

    always_comb
    begin
        levels  = '0;
        enables = '0;
        for (int i = 0; i < SHOWN; i++)
        begin
            levels[i]  = lanes[i].led;
            enables[i] = lanes[i].enabled;
        end
        word = {enables, levels};
    end

    assign pop          = out_valid_reg && m_tready;
    assign accept_ready = !skid_valid_reg;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_reg;
    assign status       = '{skid_full: skid_valid_reg, out_full: out_valid_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push && out_valid_reg && !pop)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push && out_valid_reg && !pop)
        begin
            skid_reg <= word;
        end
        else if (push)
        begin
            out_reg <= word;
        end
    end

endmodule
`default_nettype wire

@@ hdl/debounced_toggle_led_blinker.sv @@
// Top level of the debounced LED blinker: configuration registers, lanes and merge
//
//  channel  | signals                          | word
//  ---------+----------------------------------+---------------------------------
//  s        | s_tvalid s_tready s_tdata        | one tick with its button edges
//  m        | m_tvalid m_tready m_tdata        | LED levels and enables per tick
//  cfg      | cfg_valid cfg_ready cfg_index/data | one register write
//
//  One tick word is taken every cycle while s_tready is high; all lanes update together.
//  Each result is registered in the output register, or in the skid stage if m stalls.
//  An output register and a skid stage hold up to two results; s_tready drops
//  only while both are full. cfg_ready is always high.
//  Reset restores the register defaults and every lane to enabled, LED on.
`default_nettype none
module debounced_toggle_led_blinker
    import dtlb_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [3:0] button_edges, [7:4] zero
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [3:0] led_levels, [7:4] led_enables
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [HP_W-1:0]  hp_reg [HP_REGS];
    logic [DEB_W-1:0] debounce_reg;
    logic             tick;
    lane_status_t     lane_status [CHANNELS];
    merge_status_t    merge_status;

    assign cfg_ready = 1'b1;
    assign tick      = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HP_REGS; i++)
            begin
                hp_reg[i] <= HP_RESET[i];
            end
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HP0:      hp_reg[0]    <= cfg_data;
                CFG_HP1:      hp_reg[1]    <= cfg_data;
                CFG_HP2:      hp_reg[2]    <= cfg_data;
                CFG_HP3:      hp_reg[3]    <= cfg_data;
                CFG_DEBOUNCE: debounce_reg <= cfg_data[DEB_W-1:0];
                default:      ;
            endcase
        end
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        logic edge_seen;
        if (c < FIELD_W)
        begin : g_edge
            assign edge_seen = s_tdata[c];
        end
        else
        begin : g_no_edge
            assign edge_seen = 1'b0;
        end

        dtlb_lane #(
            .HP_INIT (HP_RESET[c % HP_REGS])
        ) u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .tick           (tick),
            .edge_seen      (edge_seen),
            .half_period    (hp_reg[c % HP_REGS]),
            .debounce_ticks (debounce_reg),
            .status_next    (lane_status[c])
        );
    end

    dtlb_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (tick),
        .lanes        (lane_status),
        .accept_ready (s_tready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .status       (merge_status)
    );

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        merge_status.skid_full |-> merge_status.out_full)
        else $error("skid stage holds a word while output register is empty");

    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> m_tvalid)
        else $error("accepted tick gave no result");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(merge_status.skid_full) |-> $past(m_tvalid && !m_tready && tick))
        else $error("skid stage filled without a stalled output");
`endif

endmodule
`default_nettype wire
